// ===== hdl/icr_pkg.sv =====
`timescale 1ns / 1ps

package icr_pkg;

   // Longest sequence that is stored; later elements of a sequence are dropped.
   localparam int MAX_LEN = 1024;
   localparam int IDX_W = $clog2(MAX_LEN);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_LEN - 1);

   localparam int VAL_W = 11;
   localparam int CNT_W = 19;
   localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

   // A query walking down the cell chain, one cell per cycle while the chain advances.
   typedef struct packed {
      logic             valid;
      logic             last;
      logic             active;   // element lies within MAX_LEN and is stored
      logic [IDX_W-1:0] pos;      // position of the element in its sequence
      logic [VAL_W-1:0] value;
      logic [VAL_W-1:0] rank;
      logic [IDX_W-1:0] count;    // inversions found so far against earlier cells
      logic             clash;    // an inverted pair had the larger value ranked higher
   } query_type;

endpackage

// ===== hdl/icr_cell.sv =====
`timescale 1ns / 1ps

module icr_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic [icr_pkg::IDX_W-1:0]     idx,
   input  icr_pkg::query_type            q_in,
   output icr_pkg::query_type            q_out
);

   icr_pkg::query_type              q_ff;
   logic [icr_pkg::VAL_W-1:0]       value_ff;
   logic [icr_pkg::VAL_W-1:0]       rank_ff;
   logic                            earlier;
   logic                            greater;

   // The stored element is compared only when it precedes the query in its sequence.
   assign earlier = q_ff.valid && q_ff.active && (idx < q_ff.pos);
   assign greater = earlier && (value_ff > q_ff.value);

   always_comb begin
      q_out = q_ff;
      if (greater) begin
         q_out.count = q_ff.count + 1'b1;
         if (rank_ff > q_ff.rank) begin
            q_out.clash = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff.valid <= 1'b0;
      end else if (advance) begin
         q_ff <= q_in;
      end
   end

   // The query whose position matches this cell leaves its element here.
   always_ff @(posedge clock) begin
      if (advance && q_ff.valid && q_ff.active && (q_ff.pos == idx)) begin
         value_ff <= q_ff.value;
         rank_ff  <= q_ff.rank;
      end
   end

endmodule

// ===== hdl/inversion_count_with_rank_check.sv =====
// Inversion counter with rank check: send a sequence of values, each with its rank,
// one transaction per element, and mark the final element with req_last_element.
// One transaction per cycle is accepted while the result channel keeps up. Each
// element walks down a chain of MAX_LEN cells, one cell per cycle while the chain
// advances, and the result of a sequence is held in an output register once its
// last element leaves the chain. The result gives the number of pairs in which an
// earlier value is strictly larger than a later one (saturating at the largest
// 19-bit value) and a consistent flag that drops if any such pair also has the
// larger value ranked strictly higher. Elements past MAX_LEN in one sequence are
// ignored, though a last mark on them still closes the sequence. No clearing pass
// is needed after reset, and a new sequence may follow the last element at once.
`timescale 1ns / 1ps

module inversion_count_with_rank_check (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [icr_pkg::VAL_W-1:0]     req_element_value,
   input  logic [icr_pkg::VAL_W-1:0]     req_element_rank,
   input  logic                          req_last_element,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [icr_pkg::CNT_W-1:0]     rsp_inversion_count,
   output logic                          rsp_consistent
);

   icr_pkg::query_type                   q_link [icr_pkg::MAX_LEN+1];
   icr_pkg::query_type                   tail;
   logic                                 advance;
   logic                                 req_take;
   logic [icr_pkg::IDX_W-1:0]            pos_ff;
   logic                                 full_ff;
   logic [icr_pkg::CNT_W-1:0]            run_cnt_ff;
   logic                                 run_ok_ff;
   logic [icr_pkg::CNT_W:0]              sum;
   logic [icr_pkg::CNT_W-1:0]            total;
   logic                                 rsp_valid_ff;
   logic [icr_pkg::CNT_W-1:0]            rsp_cnt_ff;
   logic                                 rsp_ok_ff;

   // The whole chain moves in lockstep. It halts only when a finished sequence
   // reaches the end of the chain while the previous result is still held by a
   // stalled receiver; otherwise the output register absorbs the wait.
   assign tail      = q_link[icr_pkg::MAX_LEN];
   assign advance   = !(rsp_valid_ff && rsp_stall && tail.valid && tail.last);
   assign req_stall = !advance;
   assign req_take  = req_valid && advance;

   // A new query enters the chain; empty cycles enter as bubbles.
   always_comb begin
      q_link[0].valid  = req_valid;
      q_link[0].last   = req_last_element;
      q_link[0].active = !full_ff;
      q_link[0].pos    = pos_ff;
      q_link[0].value  = req_element_value;
      q_link[0].rank   = req_element_rank;
      q_link[0].count  = '0;
      q_link[0].clash  = 1'b0;
   end

   // Position counter within the current sequence. Once the last storable slot
   // is used, further elements of the sequence pass through as inactive queries.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         full_ff <= 1'b0;
      end else if (req_take) begin
         if (req_last_element) begin
            pos_ff  <= '0;
            full_ff <= 1'b0;
         end else if (!full_ff) begin
            if (pos_ff == icr_pkg::LAST_IDX) begin
               full_ff <= 1'b1;
            end else begin
               pos_ff <= pos_ff + 1'b1;
            end
         end
      end
   end

   // Cell k holds the element at position k of the current sequence and compares
   // every later query against it as the query passes by.
   for (genvar k = 0; k < icr_pkg::MAX_LEN; k++) begin : g_cell
      icr_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .idx     (icr_pkg::IDX_W'(k)),
         .q_in    (q_link[k]),
         .q_out   (q_link[k+1])
      );
   end

   // Each query leaving the chain carries its complete count of inversions
   // against all earlier elements; the running total saturates.
   assign sum   = {1'b0, run_cnt_ff}
                + {{(icr_pkg::CNT_W + 1 - icr_pkg::IDX_W){1'b0}}, tail.count};
   assign total = (sum > {1'b0, icr_pkg::COUNT_MAX}) ? icr_pkg::COUNT_MAX
                                                      : sum[icr_pkg::CNT_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         run_cnt_ff <= '0;
         run_ok_ff  <= 1'b1;
      end else if (advance && tail.valid) begin
         if (tail.last) begin
            run_cnt_ff <= '0;
            run_ok_ff  <= 1'b1;
         end else begin
            run_cnt_ff <= total;
            run_ok_ff  <= run_ok_ff && !tail.clash;
         end
      end
   end

   // Output register: a finished result waits here for the receiver.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && tail.valid && tail.last) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && tail.valid && tail.last) begin
         rsp_cnt_ff <= total;
         rsp_ok_ff  <= run_ok_ff && !tail.clash;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_inversion_count = rsp_cnt_ff;
   assign rsp_consistent      = rsp_ok_ff;

`ifndef SYNTHESIS
   // A rank clash can only be seen on an inverted pair, so it implies a count.
   a_clash_has_inversion: assert property (@(posedge clock) disable iff (reset)
      !run_ok_ff |-> (run_cnt_ff != '0))
      else $error("consistent flag cleared with no inversion counted");

   a_result_clash_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ok_ff) |-> (rsp_cnt_ff != '0))
      else $error("inconsistent result reports zero inversions");

   // The position counter stops at the last slot once the sequence overflows.
   a_full_at_end: assert property (@(posedge clock) disable iff (reset)
      full_ff |-> (pos_ff == icr_pkg::LAST_IDX))
      else $error("overflow marked before last slot was used");

   // A last element restarts the position count for the next sequence.
   a_restart: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_last_element) |=> ((pos_ff == '0) && !full_ff))
      else $error("sequence position not restarted after last element");

   // A finished sequence leaving the chain always produces a waiting result.
   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      (advance && tail.valid && tail.last) |=> rsp_valid_ff)
      else $error("finished sequence did not load the output register");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the inversion counter. Sequences of (value, rank)
// elements go in one transaction per element; a behavioral tally kept in the
// bench predicts the count and consistent flag of every closed sequence, and
// a monitor compares each result transaction with the oldest prediction.
module testbench;

   // The run is stopped by force if it goes this many cycles.
   localparam int CYCLE_LIMIT = 400000;
   // Length of the deliberate result hold-off. It must outlast the time the
   // sender needs to fill the cell chain, so the input is sure to stall.
   localparam int HOLD_CYCLES = 2500;
   // Percentage of cycles in which each side idles during normal traffic.
   localparam int IDLE_PCT = 22;
   // Idle cycles between elements while the result hold-off builds up.
   localparam int PRESSURE_GAP = 7;

   // How the ranks of a random sequence relate to its values.
   typedef enum int {
      RANK_FOLLOWS,    // rank grows with value, so every inversion drops the flag
      RANK_OPPOSES,    // rank falls as value grows, so the flag holds
      RANK_SCRAMBLED   // no relation at all
   } rank_style_type;

   // One predicted result transaction.
   typedef struct packed {
      logic [icr_pkg::CNT_W-1:0] inversions;
      logic                      consistent;
   } tally_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic [icr_pkg::VAL_W-1:0]   req_element_value = '0;
   logic [icr_pkg::VAL_W-1:0]   req_element_rank = '0;
   logic                        req_last_element = 1'b0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic [icr_pkg::CNT_W-1:0]   rsp_inversion_count;
   logic                        rsp_consistent;

   // Bench copy of the block's state: the elements of the open sequence,
   // the running pair count and the running consistent flag.
   logic [icr_pkg::VAL_W-1:0]   held_values [icr_pkg::MAX_LEN];
   logic [icr_pkg::VAL_W-1:0]   held_ranks [icr_pkg::MAX_LEN];
   int                          held_count = 0;
   int                          run_inversions = 0;
   logic                        run_consistent = 1'b1;

   // Predicted results waiting for their result transaction, oldest first.
   tally_type                   pending_tallies [$];

   // When set, neither side idles.
   bit                          steady = 1'b0;
   // A test asks for a result hold-off by writing its length here; the
   // receiver process picks it up and counts it down on its own.
   int                          hold_request = 0;
   int                          hold_left = 0;

   int                          error_count = 0;
   int                          cycle_count = 0;
   int                          elements_sent = 0;
   int                          sequences_checked = 0;
   int                          stalled_offers = 0;

   inversion_count_with_rank_check u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_element_value   (req_element_value),
      .req_element_rank    (req_element_rank),
      .req_last_element    (req_last_element),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_inversion_count (rsp_inversion_count),
      .rsp_consistent      (rsp_consistent)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Folds one accepted element into the bench tally. Elements past MAX_LEN
   // are dropped, but a last mark on one still closes the sequence. The count
   // saturates at the largest value the result field can carry.
   function automatic void absorb_element(input logic [icr_pkg::VAL_W-1:0] value,
                                          input logic [icr_pkg::VAL_W-1:0] rank,
                                          input logic last);
      int        added;
      tally_type closing;
      added = 0;
      if (held_count < icr_pkg::MAX_LEN) begin
         for (int k = 0; k < held_count; k++) begin
            if (held_values[k] > value) begin
               added++;
               if (held_ranks[k] > rank)
                  run_consistent = 1'b0;
            end
         end
         if (run_inversions + added > int'(icr_pkg::COUNT_MAX))
            run_inversions = int'(icr_pkg::COUNT_MAX);
         else
            run_inversions += added;
         held_values[held_count] = value;
         held_ranks[held_count] = rank;
         held_count++;
      end
      if (last) begin
         closing.inversions = run_inversions[icr_pkg::CNT_W-1:0];
         closing.consistent = run_consistent;
         pending_tallies = {pending_tallies, closing};
         held_count = 0;
         run_inversions = 0;
         run_consistent = 1'b1;
      end
   endfunction

   // Offers one element and waits until the block takes it. Unless the bench
   // is in its steady stretch, the valid line drops for a random number of
   // idle cycles first. Once raised, valid and the payload hold until the
   // transaction is accepted.
   task automatic send_element(input logic [icr_pkg::VAL_W-1:0] value,
                               input logic [icr_pkg::VAL_W-1:0] rank,
                               input logic last);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_element_value <= value;
      req_element_rank <= rank;
      req_last_element <= last;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      absorb_element(value, rank, last);
      elements_sent++;
   endtask

   // Drops valid after the last element of a test.
   task automatic release_input();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Sends one sequence of random content. Values are mostly random picks
   // from the nominal range, sometimes from a tiny range to force equal
   // values, and sometimes from the whole 11-bit field.
   task automatic send_random_sequence(input int len);
      rank_style_type              style;
      int                          lo;
      int                          hi;
      logic [icr_pkg::VAL_W-1:0]   value;
      logic [icr_pkg::VAL_W-1:0]   rank;
      style = rank_style_type'($urandom_range(2));
      case ($urandom_range(9))
         0, 1: begin
            lo = 1;
            hi = 8;
         end
         2: begin
            lo = 0;
            hi = (1 << icr_pkg::VAL_W) - 1;
         end
         default: begin
            lo = 1;
            hi = icr_pkg::MAX_LEN;
         end
      endcase
      for (int i = 0; i < len; i++) begin
         value = icr_pkg::VAL_W'($urandom_range(hi, lo));
         case (style)
            RANK_FOLLOWS: rank = value;
            RANK_OPPOSES: rank = ~value;
            default:      rank = icr_pkg::VAL_W'($urandom_range((1 << icr_pkg::VAL_W) - 1));
         endcase
         send_element(value, rank, i == len - 1);
      end
   endtask

   // Sends random sequences until at least the given number of elements has
   // gone in. Most sequences are short so that results come often.
   task automatic send_random_batch(input int elements, input int longest);
      int sent_here;
      int len;
      sent_here = 0;
      while (sent_here < elements) begin
         if ($urandom_range(3) == 0)
            len = $urandom_range(longest, 1);
         else
            len = $urandom_range(12, 1);
         send_random_sequence(len);
         sent_here += len;
      end
   endtask

   // Waits until every predicted result has come back, then lets the cell
   // chain run empty so that a stray result would still be seen.
   task automatic wait_for_drain();
      while (pending_tallies.size() != 0)
         @(posedge clock);
      repeat (icr_pkg::MAX_LEN + 64) @(posedge clock);
   endtask

   // Hand-picked sequences for the corner cases: a single element, equal
   // values, equal ranks, a higher and a lower rank on an inverted pair, the
   // extremes of both fields, and a fully descending run.
   task automatic test_directed_cases();
      // A lone element gives no pairs and keeps the flag.
      send_element(11'd1, 11'd1, 1'b1);
      // Equal values never form an inversion.
      send_element(11'd5, 11'd5, 1'b0);
      send_element(11'd5, 11'd3, 1'b1);
      // An inversion whose ranks are equal leaves the flag set.
      send_element(11'd10, 11'd7, 1'b0);
      send_element(11'd4, 11'd7, 1'b1);
      // An inversion whose larger value is ranked higher clears the flag.
      send_element(11'd10, 11'd9, 1'b0);
      send_element(11'd4, 11'd2, 1'b1);
      // An inversion whose larger value is ranked lower keeps the flag.
      send_element(11'd10, 11'd2, 1'b0);
      send_element(11'd4, 11'd9, 1'b1);
      // Field extremes, including values outside the nominal range.
      send_element(11'd0, 11'd0, 1'b0);
      send_element(11'd2047, 11'd2047, 1'b0);
      send_element(11'd1024, 11'd1, 1'b0);
      send_element(11'd1, 11'd1024, 1'b0);
      send_element(11'd0, 11'd2047, 1'b1);
      // Strictly descending values with rising ranks: every pair counts.
      send_element(11'd2047, 11'd0, 1'b0);
      send_element(11'd1365, 11'd682, 1'b0);
      send_element(11'd682, 11'd1365, 1'b0);
      send_element(11'd1, 11'd2047, 1'b1);
      release_input();
   endtask

   // The bulk of the random traffic, with idling on both sides.
   task automatic test_random_sequences();
      send_random_batch(480, 80);
      release_input();
   endtask

   // A long stretch in which neither side idles, to run the block at full
   // rate with results leaving while new elements arrive.
   task automatic test_full_rate();
      steady = 1'b1;
      send_random_batch(240, 40);
      release_input();
      steady = 1'b0;
   endtask

   // The receiver holds off for a long stretch while the sender keeps
   // offering short sequences at a slow, even pace. Once a second finished
   // sequence reaches the end of the chain behind the held result, the chain
   // halts and the block has to stall its input until the hold-off ends.
   task automatic test_result_backpressure();
      int sent_here;
      int len;
      hold_request = HOLD_CYCLES;
      steady = 1'b1;
      sent_here = 0;
      while (sent_here < 170) begin
         len = $urandom_range(4, 1);
         for (int i = 0; i < len; i++) begin
            send_element(icr_pkg::VAL_W'($urandom_range(icr_pkg::MAX_LEN, 1)),
                         icr_pkg::VAL_W'($urandom_range(icr_pkg::MAX_LEN, 1)),
                         i == len - 1);
            req_valid <= 1'b0;
            repeat (PRESSURE_GAP) @(posedge clock);
         end
         sent_here += len;
      end
      release_input();
      steady = 1'b0;
   endtask

   // Receiver side. A requested hold-off is counted down here; otherwise the
   // stall line idles at random unless the bench is in its steady stretch.
   always @(posedge clock) begin
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
      end
   end

   // Result monitor. Every accepted result transaction is matched against
   // the oldest prediction, field by field.
   always @(posedge clock) begin
      tally_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_tallies.size() == 0) begin
            error_count++;
            $display("%0t: result with none expected: count %0d consistent %0b",
                     $time, rsp_inversion_count, rsp_consistent);
         end else begin
            want = pending_tallies.pop_front();
            sequences_checked++;
            if (rsp_inversion_count !== want.inversions) begin
               error_count++;
               $display("%0t: inversion_count expected %0d actual %0d",
                        $time, want.inversions, rsp_inversion_count);
            end
            if (rsp_consistent !== want.consistent) begin
               error_count++;
               $display("%0t: consistent expected %0b actual %0b",
                        $time, want.consistent, rsp_consistent);
            end
         end
      end
   end

   // Cycle counter with the run limit; it also counts offers the block
   // turned away, so the summary can show that the input really stalled.
   always @(posedge clock) begin
      cycle_count++;
      if (req_valid && req_stall)
         stalled_offers++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: run limit of %0d cycles reached", $time, CYCLE_LIMIT);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_cases();
      test_random_sequences();
      test_full_rate();
      test_result_backpressure();

      wait_for_drain();
      $display("Sent %0d elements and checked %0d sequence results, covering corner",
               elements_sent, sequences_checked);
      $display("cases, random idling, a full-rate stretch and a hold-off that stalled %0d offers.",
               stalled_offers);
      if (error_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ===== files.f =====
hdl/icr_pkg.sv
hdl/icr_cell.sv
hdl/inversion_count_with_rank_check.sv
tb/sv/testbench.sv
